>>> rtl/core/equ_pkg.sv
// shared types, constants and character helpers for the escape and quote decoder
`timescale 1ns / 1ps

package equ_pkg;

    // item queue between front and back
    localparam int EQU_QUEUE_DEPTH = 4;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_DANGLING   = 3'd1;
    localparam logic [2:0] ST_BAD_OCTAL  = 3'd2;
    localparam logic [2:0] ST_BAD_HEX    = 3'd3;
    localparam logic [2:0] ST_OPEN_QUOTE = 3'd4;

    // characters with a meaning of their own
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_F   = 8'h46;
    localparam logic [7:0] CH_LC_X   = 8'h78;
    localparam logic [7:0] CH_UC_X   = 8'h58;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_AL  = 8'h61;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_FF  = 8'h66;
    localparam logic [7:0] CH_LC_V   = 8'h76;
    localparam logic [7:0] CH_LC_T   = 8'h74;

    // escape sequencer states
    typedef enum logic [6:0] {
        PH_IDLE = 7'b0000001,
        PH_ESC  = 7'b0000010,
        PH_OCT2 = 7'b0000100,
        PH_OCT3 = 7'b0001000,
        PH_HEX1 = 7'b0010000,
        PH_HEX2 = 7'b0100000,
        PH_QESC = 7'b1000000
    } phase_t;

    // quote tracking states
    typedef enum logic [2:0] {
        Q_NONE   = 3'b001,
        Q_SINGLE = 3'b010,
        Q_DOUBLE = 3'b100
    } quote_t;

    // hex digit decode result
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    // one queued item: up to two result bytes
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       has;
        logic       two;
        logic       last;
        logic [2:0] status;
    } rec_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            h.val = c[3:0];
        end else if ((c >= CH_LC_A && c <= CH_LC_F) || (c >= CH_UC_A && c <= CH_UC_F)) begin
            // letters a..f and A..F share low bits 1..6
            h.val = c[3:0] + 4'd9;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic logic [7:0] control_map(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            CH_LC_N:  r = 8'h0A;
            CH_LC_AL: r = 8'h07;
            CH_LC_B:  r = 8'h08;
            CH_LC_R:  r = 8'h0D;
            CH_LC_FF: r = 8'h0C;
            CH_LC_V:  r = 8'h0B;
            CH_LC_T:  r = 8'h09;
            default:  r = c;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/equ_front.sv
// front part: accepts characters, tracks quotes and escapes, builds result items
`timescale 1ns / 1ps

module equ_front
    import equ_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       end_of_string,
    output logic       push_valid,
    input  logic       push_ready,
    output rec_t       push_rec
);

    phase_t     phase_reg, phase_next;
    quote_t     quote_reg, quote_next;
    logic [7:0] accum_reg, accum_next;
    logic [2:0] err_reg, err_next;

    logic       accept;
    logic [7:0] qc;
    logic       is_oct;
    hex_t       hx;
    logic [1:0] n;
    logic [7:0] b0, b1;
    logic [2:0] status;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;

    // classify the character against the current state
    always_comb
    begin
        qc         = (quote_reg == Q_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
        is_oct     = (in_char >= CH_ZERO) && (in_char <= CH_SEVEN);
        hx         = hex_decode(in_char);
        n          = 2'd0;
        b0         = 8'd0;
        b1         = 8'd0;
        phase_next = phase_reg;
        quote_next = quote_reg;
        accum_next = accum_reg;
        err_next   = err_reg;
        if (err_reg == ST_OK) begin
            unique case (phase_reg)
                PH_ESC:
                begin
                    if (is_oct) begin
                        accum_next = {5'd0, in_char[2:0]};
                        phase_next = PH_OCT2;
                    end else if (in_char == CH_LC_X || in_char == CH_UC_X) begin
                        accum_next = 8'd0;
                        phase_next = PH_HEX1;
                    end else begin
                        n          = 2'd1;
                        b0         = control_map(in_char);
                        phase_next = PH_IDLE;
                    end
                end
                PH_OCT2, PH_OCT3:
                begin
                    if (is_oct) begin
                        accum_next = {accum_reg[4:0], in_char[2:0]};
                        if (phase_reg == PH_OCT3) begin
                            n          = 2'd1;
                            b0         = accum_next;
                            phase_next = PH_IDLE;
                        end else begin
                            phase_next = PH_OCT3;
                        end
                    end else begin
                        err_next = ST_BAD_OCTAL;
                    end
                end
                PH_HEX1, PH_HEX2:
                begin
                    if (hx.ok) begin
                        accum_next = {accum_reg[3:0], hx.val};
                        if (phase_reg == PH_HEX2) begin
                            n          = 2'd1;
                            b0         = accum_next;
                            phase_next = PH_IDLE;
                        end else begin
                            phase_next = PH_HEX2;
                        end
                    end else begin
                        err_next = ST_BAD_HEX;
                    end
                end
                PH_QESC:
                begin
                    if (in_char != qc) begin
                        n  = 2'd2;
                        b0 = CH_BSLASH;
                        b1 = in_char;
                    end else begin
                        n  = 2'd1;
                        b0 = in_char;
                    end
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    if (quote_reg == Q_NONE) begin
                        if (in_char == CH_BSLASH) begin
                            phase_next = PH_ESC;
                        end else if (in_char == CH_SQUOTE) begin
                            quote_next = Q_SINGLE;
                        end else if (in_char == CH_DQUOTE) begin
                            quote_next = Q_DOUBLE;
                        end else begin
                            n  = 2'd1;
                            b0 = in_char;
                        end
                    end else begin
                        if (in_char == CH_BSLASH) begin
                            phase_next = PH_QESC;
                        end else if (in_char == qc) begin
                            quote_next = Q_NONE;
                        end else begin
                            n  = 2'd1;
                            b0 = in_char;
                        end
                    end
                end
            endcase
        end

        // end of string: report what is still pending
        status = ST_OK;
        if (end_of_string) begin
            if (err_next == ST_OK) begin
                if (phase_next == PH_ESC || phase_next == PH_QESC) begin
                    status = ST_DANGLING;
                end else if (phase_next == PH_OCT2 || phase_next == PH_OCT3) begin
                    status = ST_BAD_OCTAL;
                end else if (phase_next == PH_HEX1 || phase_next == PH_HEX2) begin
                    status = ST_BAD_HEX;
                end else if (quote_next != Q_NONE) begin
                    status = ST_OPEN_QUOTE;
                end
            end else begin
                status = err_next;
            end
        end
    end

    // queue write for items that give at least one result
    always_comb
    begin
        push_valid      = accept && ((n != 2'd0) || end_of_string);
        push_rec.byte0  = b0;
        push_rec.byte1  = b1;
        push_rec.has    = (n != 2'd0);
        push_rec.two    = (n == 2'd2);
        push_rec.last   = end_of_string;
        push_rec.status = status;
    end

    // decoder state, back to reset after the final character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE;
            quote_reg <= Q_NONE;
            accum_reg <= 8'd0;
            err_reg   <= ST_OK;
        end else if (accept) begin
            if (end_of_string) begin
                phase_reg <= PH_IDLE;
                quote_reg <= Q_NONE;
                accum_reg <= 8'd0;
                err_reg   <= ST_OK;
            end else begin
                phase_reg <= phase_next;
                quote_reg <= quote_next;
                accum_reg <= accum_next;
                err_reg   <= err_next;
            end
        end
    end

endmodule

>>> rtl/core/equ_queue.sv
// short item queue between the front and back parts
`timescale 1ns / 1ps

module equ_queue
    import equ_pkg::*;
#(
    parameter int DEPTH = EQU_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  rec_t wr_rec,
    output logic rd_valid,
    input  logic rd_ready,
    output rec_t rd_rec
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    rec_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr, do_rd;

    assign wr_ready = (count_reg != CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_rec   = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_rec;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/equ_back.sv
// back part: splits queued items into results and holds them in an output register
`timescale 1ns / 1ps

module equ_back
    import equ_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rd_valid,
    output logic       rd_ready,
    input  rec_t       rd_rec,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       has_char,
    output logic       run_last,
    output logic       string_done,
    output logic [2:0] status
);

    logic       valid_reg, valid_next;
    logic       second_reg, second_next;
    logic [7:0] char_reg, char_next;
    logic       has_reg, has_next;
    logic       rlast_reg, rlast_next;
    logic       done_reg, done_next;
    logic [2:0] status_reg, status_next;
    logic       load;

    assign load = !valid_reg || out_ready;

    // pick the next result from the head item
    always_comb
    begin
        valid_next  = valid_reg;
        second_next = second_reg;
        char_next   = char_reg;
        has_next    = has_reg;
        rlast_next  = rlast_reg;
        done_next   = done_reg;
        status_next = status_reg;
        rd_ready    = 1'b0;
        if (load) begin
            valid_next = rd_valid;
            if (rd_valid) begin
                if (second_reg) begin
                    char_next   = rd_rec.byte1;
                    has_next    = 1'b1;
                    rlast_next  = 1'b1;
                    done_next   = rd_rec.last;
                    status_next = rd_rec.status;
                    second_next = 1'b0;
                    rd_ready    = 1'b1;
                end else begin
                    char_next   = rd_rec.byte0;
                    has_next    = rd_rec.has;
                    rlast_next  = !rd_rec.two;
                    done_next   = rd_rec.last && !rd_rec.two;
                    status_next = rd_rec.two ? ST_OK : rd_rec.status;
                    second_next = rd_rec.two;
                    rd_ready    = !rd_rec.two;
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg   <= char_next;
        has_reg    <= has_next;
        rlast_reg  <= rlast_next;
        done_reg   <= done_next;
        status_reg <= status_next;
    end

    assign out_valid   = valid_reg;
    assign out_char    = char_reg;
    assign has_char    = has_reg;
    assign run_last    = rlast_reg;
    assign string_done = done_reg;
    assign status      = status_reg;

endmodule

>>> rtl/core/escape_quote_unescaper_unit.sv
// top level of the backslash escape and quote decoder
// path: an accepted item is written into the item queue, then loaded into the output register
// throughput: one item per cycle while the queue has room; an item giving two bytes holds the output side for both
// the item queue (QUEUE_DEPTH entries) absorbs the second bytes of such items and output stalls
// reset: asynchronous, active low; clears decoder state, queue and output valid
`timescale 1ns / 1ps

module escape_quote_unescaper_unit
    import equ_pkg::*;
#(
    parameter int QUEUE_DEPTH = EQU_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       end_of_string,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       has_char,
    output logic       run_last,
    output logic       string_done,
    output logic [2:0] status
);

    logic q_wr_valid, q_wr_ready, q_rd_valid, q_rd_ready;
    rec_t q_wr_rec, q_rd_rec;

    // character classification and decoder state
    equ_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_char       (in_char),
        .end_of_string (end_of_string),
        .push_valid    (q_wr_valid),
        .push_ready    (q_wr_ready),
        .push_rec      (q_wr_rec)
    );

    // item queue
    equ_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_rec   (q_wr_rec),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_rec   (q_rd_rec)
    );

    // result output
    equ_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_valid    (q_rd_valid),
        .rd_ready    (q_rd_ready),
        .rd_rec      (q_rd_rec),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .has_char    (has_char),
        .run_last    (run_last),
        .string_done (string_done),
        .status      (status)
    );

    // end of string is always the last result of its item
    a_done_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && string_done) |-> run_last)
        else $error("string_done without run_last");

    // a nonzero status only on the final result of a string
    a_status_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> string_done)
        else $error("status reported before end of string");

    // a result without a byte only closes a string
    a_empty_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !has_char) |-> (string_done && out_char == 8'd0))
        else $error("empty result outside end of string");

    // the back part pops the queue only while it holds an item
    a_queue_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (q_rd_ready) |-> q_rd_valid)
        else $error("queue read while empty");

endmodule

>>> tb/sv/equ_result_checker.sv
// result checker for the escape and quote decoder: predicts every result and compares
`timescale 1ns / 1ps

module equ_result_checker
    import equ_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       end_of_string,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_char,
    input  logic       has_char,
    input  logic       run_last,
    input  logic       string_done,
    input  logic [2:0] status,
    output int         fail_count,
    output int         pending
);

    // one predicted output item
    typedef struct packed {
        logic [7:0] ch;
        logic       has;
        logic       last;
        logic       done;
        logic [2:0] st;
    } decoded_t;

    decoded_t decoded_q[$];

    // predictor copy of the decoder state
    quote_t     quote_st;
    phase_t     phase_st;
    logic [7:0] code_acc;
    logic [2:0] sticky_err;

    function automatic logic is_octal_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_SEVEN);
    endfunction

    // nibble value of a hex digit, bit 4 set when c is not a hex digit
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= CH_ZERO && c <= CH_NINE)
            d = c - CH_ZERO;
        else if (c >= CH_LC_A && c <= CH_LC_F)
            d = c - CH_LC_A + 8'd10;
        else if (c >= CH_UC_A && c <= CH_UC_F)
            d = c - CH_UC_A + 8'd10;
        else
            return 5'h10;
        return {1'b0, d[3:0]};
    endfunction

    // byte named by a letter after a backslash
    function automatic logic [7:0] escape_byte(input logic [7:0] c);
        case (c)
            CH_LC_N:  return 8'h0A;
            CH_LC_AL: return 8'h07;
            CH_LC_B:  return 8'h08;
            CH_LC_R:  return 8'h0D;
            CH_LC_FF: return 8'h0C;
            CH_LC_V:  return 8'h0B;
            CH_LC_T:  return 8'h09;
            default:  return c;
        endcase
    endfunction

    function automatic void clear_decoder();
        quote_st   = Q_NONE;
        phase_st   = PH_IDLE;
        code_acc   = 8'h00;
        sticky_err = ST_OK;
    endfunction

    // advance the state by one character and queue the results it causes
    function automatic void predict_item(input logic [7:0] c, input logic eos);
        logic [7:0] emitted [0:1];
        logic [7:0] qc;
        logic [4:0] nib;
        logic [2:0] final_st;
        decoded_t   r;
        int         n;
        int         count;
        n          = 0;
        emitted[0] = 8'h00;
        emitted[1] = 8'h00;
        final_st   = ST_OK;
        qc         = (quote_st == Q_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
        if (sticky_err == ST_OK) begin
            case (phase_st)
                PH_ESC:
                begin
                    if (is_octal_digit(c)) begin
                        code_acc = c - CH_ZERO;
                        phase_st = PH_OCT2;
                    end else if (c == CH_LC_X || c == CH_UC_X) begin
                        code_acc = 8'h00;
                        phase_st = PH_HEX1;
                    end else begin
                        emitted[n] = escape_byte(c);
                        n++;
                        phase_st = PH_IDLE;
                    end
                end
                PH_OCT2, PH_OCT3:
                begin
                    if (is_octal_digit(c)) begin
                        // shift by one octal digit, upper bits drop off
                        code_acc = {code_acc[4:0], c[2:0]};
                        if (phase_st == PH_OCT3) begin
                            emitted[n] = code_acc;
                            n++;
                            phase_st = PH_IDLE;
                        end else begin
                            phase_st = PH_OCT3;
                        end
                    end else begin
                        sticky_err = ST_BAD_OCTAL;
                    end
                end
                PH_HEX1, PH_HEX2:
                begin
                    nib = hex_nibble(c);
                    if (nib[4]) begin
                        sticky_err = ST_BAD_HEX;
                    end else begin
                        code_acc = {code_acc[3:0], nib[3:0]};
                        if (phase_st == PH_HEX2) begin
                            emitted[n] = code_acc;
                            n++;
                            phase_st = PH_IDLE;
                        end else begin
                            phase_st = PH_HEX2;
                        end
                    end
                end
                PH_QESC:
                begin
                    // backslash survives unless it escapes the open quote
                    if (c != qc) begin
                        emitted[n] = CH_BSLASH;
                        n++;
                    end
                    emitted[n] = c;
                    n++;
                    phase_st = PH_IDLE;
                end
                default:
                begin
                    phase_st = PH_IDLE;
                    if (quote_st == Q_NONE) begin
                        if (c == CH_BSLASH)
                            phase_st = PH_ESC;
                        else if (c == CH_SQUOTE)
                            quote_st = Q_SINGLE;
                        else if (c == CH_DQUOTE)
                            quote_st = Q_DOUBLE;
                        else begin
                            emitted[n] = c;
                            n++;
                        end
                    end else begin
                        if (c == CH_BSLASH)
                            phase_st = PH_QESC;
                        else if (c == qc)
                            quote_st = Q_NONE;
                        else begin
                            emitted[n] = c;
                            n++;
                        end
                    end
                end
            endcase
        end

        // end of string: pending escape or open quote becomes the status
        if (eos) begin
            if (sticky_err == ST_OK) begin
                case (phase_st)
                    PH_ESC, PH_QESC:  sticky_err = ST_DANGLING;
                    PH_OCT2, PH_OCT3: sticky_err = ST_BAD_OCTAL;
                    PH_HEX1, PH_HEX2: sticky_err = ST_BAD_HEX;
                    default:
                    begin
                        if (quote_st != Q_NONE)
                            sticky_err = ST_OPEN_QUOTE;
                    end
                endcase
            end
            final_st = sticky_err;
        end

        count = (eos && n == 0) ? 1 : n;
        for (int k = 0; k < count; k++) begin
            r.ch   = (k < n) ? emitted[k] : 8'h00;
            r.has  = (k < n);
            r.last = (k == count - 1);
            r.done = r.last && eos;
            r.st   = r.done ? final_st : ST_OK;
            decoded_q.push_back(r);
        end

        if (eos)
            clear_decoder();
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    // compare one output item with the oldest prediction
    function automatic void check_result();
        decoded_t want;
        if (decoded_q.size() == 0) begin
            fail_count++;
            $display("%0t: result with none expected, expected nothing, actual %h %b %b %b %0d",
                     $time, out_char, has_char, run_last, string_done, status);
            return;
        end
        want = decoded_q.pop_front();
        compare_field("out_char", want.ch, out_char);
        compare_field("has_char", {7'd0, want.has}, {7'd0, has_char});
        compare_field("run_last", {7'd0, want.last}, {7'd0, run_last});
        compare_field("string_done", {7'd0, want.done}, {7'd0, string_done});
        compare_field("status", {5'd0, want.st}, {5'd0, status});
    endfunction

    // watch both channels; inputs predicted before outputs are checked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            clear_decoder();
            decoded_q.delete();
            pending = 0;
        end else begin
            if (in_valid && in_ready)
                predict_item(in_char, end_of_string);
            if (out_valid && out_ready)
                check_result();
            pending = decoded_q.size();
        end
    end

endmodule

>>> tb/sv/escape_quote_unescaper_unit_tb.sv
// testbench top for the escape and quote decoder: stimulus, output stalls and verdict
`timescale 1ns / 1ps

module escape_quote_unescaper_unit_tb;
    import equ_pkg::*;

    localparam int ITEMS_PER_PHASE = 420;
    localparam int PRESSURE_ITEMS  = 40;
    localparam int HOLD_CYCLES     = 150;
    localparam int DRAIN_CYCLES    = 20;
    localparam int CYCLE_LIMIT     = 300000;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       in_valid      = 1'b0;
    logic       in_ready;
    logic [7:0] in_char       = 8'h01;
    logic       end_of_string = 1'b0;
    logic       out_valid;
    logic       out_ready     = 1'b0;
    logic [7:0] out_char;
    logic       has_char;
    logic       run_last;
    logic       string_done;
    logic [2:0] status;

    int fail_count;
    int pending;
    int cycle_count  = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int phase_items  = 0;
    bit hold_go      = 1'b0;

    logic [7:0] text_q[$];

    escape_quote_unescaper_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_char       (in_char),
        .end_of_string (end_of_string),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_char      (out_char),
        .has_char      (has_char),
        .run_last      (run_last),
        .string_done   (string_done),
        .status        (status)
    );

    equ_result_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_char       (in_char),
        .end_of_string (end_of_string),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_char      (out_char),
        .has_char      (has_char),
        .run_last      (run_last),
        .string_done   (string_done),
        .status        (status),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // 8 ns clock
    always #4 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // output side: random stalls, plus one long hold-off on request
    initial
    begin
        forever begin
            @(negedge clk);
            if (hold_go) begin
                hold_go = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // character with no special meaning outside quotes
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255));
        while (c == CH_BSLASH || c == CH_SQUOTE || c == CH_DQUOTE);
        return c;
    endfunction

    function automatic logic [7:0] char_except(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255));
        while (c == a || c == b);
        return c;
    endfunction

    function automatic logic [7:0] octal_digit();
        return CH_ZERO + 8'($urandom_range(0, 7));
    endfunction

    function automatic logic [7:0] hex_digit();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
            return CH_ZERO + 8'(v);
        return ($urandom_range(0, 1) ? CH_LC_A : CH_UC_A) + 8'(v - 10);
    endfunction

    function automatic bit is_hex_char(input logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LC_A && c <= CH_LC_F)
            || (c >= CH_UC_A && c <= CH_UC_F);
    endfunction

    // one well-formed piece of a string
    function automatic void add_token();
        logic [7:0] q;
        logic [7:0] c;
        case ($urandom_range(0, 9))
            4:
            begin
                text_q.push_back(CH_BSLASH);
                case ($urandom_range(0, 6))
                    0:       text_q.push_back(CH_LC_N);
                    1:       text_q.push_back(CH_LC_AL);
                    2:       text_q.push_back(CH_LC_B);
                    3:       text_q.push_back(CH_LC_R);
                    4:       text_q.push_back(CH_LC_FF);
                    5:       text_q.push_back(CH_LC_V);
                    default: text_q.push_back(CH_LC_T);
                endcase
            end
            5:
            begin
                text_q.push_back(CH_BSLASH);
                repeat (3) text_q.push_back(octal_digit());
            end
            6:
            begin
                text_q.push_back(CH_BSLASH);
                text_q.push_back($urandom_range(0, 1) ? CH_LC_X : CH_UC_X);
                repeat (2) text_q.push_back(hex_digit());
            end
            7:
            begin
                // escaped character that starts no number
                do c = 8'($urandom_range(1, 255));
                while ((c >= CH_ZERO && c <= CH_SEVEN) || c == CH_LC_X || c == CH_UC_X);
                text_q.push_back(CH_BSLASH);
                text_q.push_back(c);
            end
            8, 9:
            begin
                // quoted section, sometimes with backslash pairs inside
                q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
                text_q.push_back(q);
                repeat ($urandom_range(0, 4)) begin
                    if ($urandom_range(0, 3) == 0) begin
                        text_q.push_back(CH_BSLASH);
                        text_q.push_back($urandom_range(0, 1) ? q : char_except(8'h00, 8'h00));
                    end else begin
                        text_q.push_back(char_except(q, CH_BSLASH));
                    end
                end
                text_q.push_back(q);
            end
            default: text_q.push_back(plain_char());
        endcase
    endfunction

    // random string: well-formed tokens, a quarter of them with an added tail that is mostly broken
    function automatic void build_string();
        logic [7:0] c;
        text_q.delete();
        repeat ($urandom_range(1, 8)) add_token();
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 7))
                0: text_q.push_back(CH_BSLASH);
                1:
                begin
                    // bad octal digit, then characters that are swallowed
                    text_q.push_back(CH_BSLASH);
                    repeat ($urandom_range(1, 2)) text_q.push_back(octal_digit());
                    do c = 8'($urandom_range(1, 255));
                    while (c >= CH_ZERO && c <= CH_SEVEN);
                    text_q.push_back(c);
                    repeat ($urandom_range(0, 3)) text_q.push_back(plain_char());
                end
                2:
                begin
                    // bad hex digit, then swallowed characters
                    text_q.push_back(CH_BSLASH);
                    text_q.push_back($urandom_range(0, 1) ? CH_LC_X : CH_UC_X);
                    if ($urandom_range(0, 1))
                        text_q.push_back(hex_digit());
                    do c = 8'($urandom_range(1, 255));
                    while (is_hex_char(c));
                    text_q.push_back(c);
                    repeat ($urandom_range(0, 3)) text_q.push_back(plain_char());
                end
                3:
                begin
                    text_q.push_back($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE);
                    repeat ($urandom_range(0, 3)) text_q.push_back(plain_char());
                end
                4: repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(1, 255)));
                5:
                begin
                    // dangling backslash inside quotes
                    text_q.push_back($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE);
                    text_q.push_back(CH_BSLASH);
                end
                6:
                begin
                    text_q.push_back(CH_BSLASH);
                    repeat ($urandom_range(1, 2)) text_q.push_back(octal_digit());
                end
                default:
                begin
                    text_q.push_back(CH_BSLASH);
                    text_q.push_back(CH_LC_X);
                    if ($urandom_range(0, 1))
                        text_q.push_back(hex_digit());
                end
            endcase
        end
    endfunction

    // offer one item after a random gap and hold it until accepted
    task automatic send_char(input logic [7:0] c, input logic eos);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        in_char       <= c;
        end_of_string <= eos;
        do @(posedge clk);
        while (!in_ready);
        phase_items++;
        @(negedge clk);
    endtask

    task automatic send_text();
        foreach (text_q[i])
            send_char(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic send_literal(input string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
        send_text();
    endtask

    // stimulus
    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 77; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 77; end
                default: begin tx_idle_pct = 18; rx_stall_pct = 18; end
            endcase
            phase_items = 0;

            if (p == 0) begin
                // extremes of the character, escapes, quotes and the dangling, bad octal and open quote errors
                send_literal("\377\001");
                send_literal("\\n\\400");
                send_literal("\\xAf\"\\\"\\q\"");
                send_literal("\\08z");
                send_literal("'a");
                send_literal("\\");

                // long output hold-off while items keep coming
                hold_go = 1'b1;
                while (phase_items < PRESSURE_ITEMS + 25) begin
                    build_string();
                    send_text();
                end
            end

            while (phase_items < ITEMS_PER_PHASE) begin
                build_string();
                send_text();
            end
        end
        in_valid <= 1'b0;

        // drain outstanding results, then allow for trailing output
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
